// ----- sv/arm_system_bitfield_exec_macros.svh -----
// assertion macros for the arm system and bitfield execute unit
`ifndef ARM_SYSTEM_BITFIELD_EXEC_MACROS_SVH
`define ARM_SYSTEM_BITFIELD_EXEC_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define ABX_ASSERT_HOLD(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("abx assertion failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define ABX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("abx assertion failed");

`endif

// ----- sv/abx_pkg.sv -----
// types and constants shared by the execute unit files
package abx_pkg;

  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_SVC      = 4'd1,
    OP_MRS      = 4'd2,
    OP_SETEND   = 4'd3,
    OP_CPS      = 4'd4,
    OP_BFC      = 4'd5,
    OP_BFI      = 4'd6,
    OP_CLZ      = 4'd7,
    OP_BKPT     = 4'd8,
    OP_DEADBEEF = 4'd9
  } op_e;

  localparam logic [1:0] STOP_NONE   = 2'd0;
  localparam logic [1:0] STOP_BREAK  = 2'd1;
  localparam logic [1:0] STOP_MARKER = 2'd2;

  localparam logic [31:0] MODE_MASK  = 32'h0000_001F;
  localparam logic [31:0] MODE_SVC   = 32'h0000_0013;
  localparam logic [31:0] T_MASK     = 32'h0000_0020;
  localparam logic [31:0] F_MASK     = 32'h0000_0040;
  localparam logic [31:0] I_MASK     = 32'h0000_0080;
  localparam logic [31:0] A_MASK     = 32'h0000_0100;
  localparam logic [31:0] E_MASK     = 32'h0000_0200;
  localparam logic [31:0] IT_MASK    = 32'h0600_FC00;
  localparam logic [31:0] SVC_VECTOR = 32'h0000_0008;
  localparam logic [3:0]  PC_INDEX   = 4'd15;
  localparam logic [3:0]  LR_INDEX   = 4'd14;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [31:0] instr_word;
    logic [31:0] next_pc;
    logic [31:0] rd_value;
    logic [31:0] rn_value;
    logic [31:0] rm_value;
  } abx_in_t;

  typedef struct packed {
    logic        reg_write;
    logic [3:0]  reg_index;
    logic [31:0] reg_value;
    logic [31:0] pc_out;
    logic [31:0] status_word;
    logic        halt;
    logic [1:0]  stop_cause;
  } abx_out_t;

  typedef struct packed {
    logic [31:0] cpsr;
    logic [31:0] spsr;
  } psr_t;

endpackage

// ----- sv/abx_if.sv -----
// valid/ready channel interfaces for instructions and results
interface abx_in_if import abx_pkg::*; ();
  logic    valid;
  logic    ready;
  abx_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface abx_out_if import abx_pkg::*; ();
  logic     valid;
  logic     ready;
  abx_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/arm_system_bitfield_exec.sv -----
// top level of the arm system and bitfield execute unit

// Execute unit for A32 SVC, MRS, SETEND, CPS, BFC, BFI, CLZ, no-ops, BKPT and
// the dead-beef halt marker. It holds CPSR and SPSR (both zero after reset)
// and returns exactly one result transaction per instruction transaction.
// Throughput is one instruction per cycle while the result is not stalled.
// An accepted instruction sits in the input register, goes through a single
// pass of mask/shift logic and a nibble-based leading-zero encoder, and is
// then presented from the result register. CPSR and SPSR update at the
// edge where an instruction moves into the result register, so back-to-back
// instructions always see the status left by the one before. A stalled
// result holds the result register and the input register keeps one
// instruction behind it; with both full the input is not ready.
// No clearing pass after reset.
`include "arm_system_bitfield_exec_macros.svh"

module arm_system_bitfield_exec import abx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  abx_in_if.sink    in_i,
  abx_out_if.source out_o
);

  // input stage
  logic     in_vld_q;
  abx_in_t  in_q;

  // result stage
  logic     out_vld_q;
  abx_out_t out_q;

  // status registers
  psr_t     psr_q;
  psr_t     psr_d;
  abx_out_t res;

  logic     out_load;
  logic     in_load;

  // result register takes a new transaction when empty or being drained
  assign out_load   = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || out_load;
  assign in_load    = in_i.valid && in_i.ready;

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  abx_exec u_exec (
    .item_i (in_q),
    .psr_i  (psr_q),
    .psr_o  (psr_d),
    .res_o  (res)
  );

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      psr_q     <= '0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (!out_vld_q || out_o.ready) begin
        out_vld_q <= in_vld_q;
      end
      if (out_load) begin
        psr_q <= psr_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_q <= in_i.data;
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  // the presented status word always matches the live cpsr
  `ABX_ASSERT_HOLD(a_status_matches, out_vld_q, out_q.status_word == psr_q.cpsr)

  // status registers only move when an instruction retires into the result stage
  `ABX_ASSERT_NEXT(a_psr_stable, !out_load, $stable(psr_q))

  // svc banks the old cpsr and vectors
  `ABX_ASSERT_NEXT(a_svc_entry, out_load && (in_q.opcode == OP_SVC),
                   (psr_q.spsr == $past(psr_q.cpsr)) && (out_q.pc_out == SVC_VECTOR))

  // no writeback means zero index and value
  `ABX_ASSERT_HOLD(a_no_wb_zero, out_vld_q && !out_q.reg_write,
                   (out_q.reg_index == '0) && (out_q.reg_value == '0))

endmodule

// ----- sv/abx_clz.sv -----
// count leading zeros of a 32-bit word, nibble priority encoder
module abx_clz (
  input  logic [31:0] value_i,
  output logic [5:0]  count_o
);

  function automatic logic [2:0] nib_clz(input logic [3:0] nib);
    logic [2:0] n;
    begin
      if (nib[3]) n = 3'd0;
      else if (nib[2]) n = 3'd1;
      else if (nib[1]) n = 3'd2;
      else if (nib[0]) n = 3'd3;
      else n = 3'd4;
      return n;
    end
  endfunction

  always_comb begin
    logic       found;
    logic [3:0] nib;
    found   = 1'b0;
    count_o = 6'd32;
    // nibble 0 is the most significant one
    for (int k = 0; k < 8; k++) begin
      nib = value_i[31 - 4 * k -: 4];
      if (!found && (nib != 4'd0)) begin
        count_o = 6'(4 * k) + {3'd0, nib_clz(nib)};
        found   = 1'b1;
      end
    end
  end

endmodule

// ----- sv/abx_exec.sv -----
// instruction evaluation: result fields and next status registers
module abx_exec import abx_pkg::*; (
  input  abx_in_t  item_i,
  input  psr_t     psr_i,
  output psr_t     psr_o,
  output abx_out_t res_o
);

  logic [3:0]  rd;
  logic [4:0]  lsb;
  logic [4:0]  msb;
  logic        rd_ok;
  logic        field_ok;
  logic [31:0] fmask;
  logic [31:0] cps_mask;
  logic [5:0]  clz;

  abx_clz u_clz (
    .value_i (item_i.rm_value),
    .count_o (clz)
  );

  assign rd       = item_i.instr_word[15:12];
  assign lsb      = item_i.instr_word[11:7];
  assign msb      = item_i.instr_word[20:16];
  assign rd_ok    = (rd != PC_INDEX);
  assign field_ok = rd_ok && (msb >= lsb);
  // only meaningful when msb >= lsb
  assign fmask    = ({32{1'b1}} << lsb) & ({32{1'b1}} >> (5'd31 - msb));

  always_comb begin
    cps_mask = '0;
    if (item_i.instr_word[8]) cps_mask = cps_mask | A_MASK;
    if (item_i.instr_word[7]) cps_mask = cps_mask | I_MASK;
    if (item_i.instr_word[6]) cps_mask = cps_mask | F_MASK;
  end

  always_comb begin
    psr_o        = psr_i;
    res_o        = '0;
    res_o.pc_out = item_i.next_pc;
    case (item_i.opcode)
      OP_SVC: begin
        psr_o.spsr      = psr_i.cpsr;
        psr_o.cpsr      = (psr_i.cpsr & ~(IT_MASK | T_MASK | MODE_MASK)) | I_MASK | MODE_SVC;
        res_o.reg_write = 1'b1;
        res_o.reg_index = LR_INDEX;
        res_o.reg_value = item_i.next_pc;
        res_o.pc_out    = SVC_VECTOR;
      end
      OP_MRS: begin
        if (rd_ok) begin
          res_o.reg_write = 1'b1;
          res_o.reg_index = rd;
          res_o.reg_value = item_i.instr_word[22] ? psr_i.spsr : psr_i.cpsr;
        end
      end
      OP_SETEND: begin
        psr_o.cpsr = item_i.instr_word[9] ? (psr_i.cpsr | E_MASK) : (psr_i.cpsr & ~E_MASK);
      end
      OP_CPS: begin
        psr_o.cpsr = item_i.instr_word[18] ? (psr_i.cpsr | cps_mask)
                                           : (psr_i.cpsr & ~cps_mask);
        if (item_i.instr_word[17]) begin
          psr_o.cpsr = (psr_o.cpsr & ~MODE_MASK) | (item_i.instr_word & MODE_MASK);
        end
      end
      OP_BFC: begin
        if (field_ok) begin
          res_o.reg_write = 1'b1;
          res_o.reg_index = rd;
          res_o.reg_value = item_i.rd_value & ~fmask;
        end
      end
      OP_BFI: begin
        if (field_ok) begin
          res_o.reg_write = 1'b1;
          res_o.reg_index = rd;
          res_o.reg_value = (item_i.rd_value & ~fmask) | ((item_i.rn_value << lsb) & fmask);
        end
      end
      OP_CLZ: begin
        if (rd_ok) begin
          res_o.reg_write = 1'b1;
          res_o.reg_index = rd;
          res_o.reg_value = {26'd0, clz};
        end
      end
      OP_BKPT: begin
        res_o.halt       = 1'b1;
        res_o.stop_cause = STOP_BREAK;
      end
      OP_DEADBEEF: begin
        res_o.halt       = 1'b1;
        res_o.stop_cause = STOP_MARKER;
      end
      default: begin
        // nop and unused codes
        res_o.stop_cause = STOP_NONE;
      end
    endcase
    res_o.status_word = psr_o.cpsr;
  end

endmodule

// ----- bench/tb_arm_system_bitfield_exec.sv -----
// self-checking testbench for the arm system and bitfield execute unit
`timescale 1ns / 100ps

module tb_arm_system_bitfield_exec import abx_pkg::*; ();

  // opcodes 10 to 15 carry no operation and must behave like a nop
  localparam logic [3:0] OP_UNUSED_MIN = 4'd10;
  localparam logic [3:0] OP_UNUSED_MAX = 4'd15;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 150;
  localparam int REPORT_MAX   = 30;

  // one pending instruction; chk marks a hand-typed expected result
  typedef struct packed {
    logic     chk;
    abx_in_t  ins;
    abx_out_t want;
  } instr_slot_t;

  localparam abx_out_t NO_CHECK = '0;

  // directed rows: chk, opcode, instr_word, next_pc, rd, rn, rm, expected result
  // expected result: reg_write, reg_index, reg_value, pc_out, status_word, halt, cause
  localparam instr_slot_t DIR_TAB [25] = '{
    // status reads right after reset see zero
    {1'b1, OP_MRS, 32'hE10F0000, 32'h00000104, 32'hFFFFFFFF, 32'h0, 32'h0,
     {1'b1, 4'd0, 32'h0, 32'h00000104, 32'h0, 1'b0, STOP_NONE}},
    {1'b1, OP_MRS, 32'hE14F1000, 32'h00000108, 32'h0, 32'h0, 32'h0,
     {1'b1, 4'd1, 32'h0, 32'h00000108, 32'h0, 1'b0, STOP_NONE}},
    // nop and unused opcode with every field at its extremes
    {1'b1, OP_NOP, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
     {1'b0, 4'd0, 32'h0, 32'hFFFFFFFF, 32'h0, 1'b0, STOP_NONE}},
    {1'b1, OP_UNUSED_MAX, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
     {1'b0, 4'd0, 32'h0, 32'h0, 32'h0, 1'b0, STOP_NONE}},
    // halt reporting only
    {1'b1, OP_BKPT, 32'hE1200070, 32'h00000200, 32'h0, 32'h0, 32'h0,
     {1'b0, 4'd0, 32'h0, 32'h00000200, 32'h0, 1'b1, STOP_BREAK}},
    {1'b1, OP_DEADBEEF, 32'hDEADBEEF, 32'h00000204, 32'h0, 32'h0, 32'h0,
     {1'b0, 4'd0, 32'h0, 32'h00000204, 32'h0, 1'b1, STOP_MARKER}},
    // leading-zero count: zero, all ones, lowest bit, destination pc
    {1'b1, OP_CLZ, 32'hE16F3F10, 32'h00000010, 32'h0, 32'h0, 32'h0,
     {1'b1, 4'd3, 32'd32, 32'h00000010, 32'h0, 1'b0, STOP_NONE}},
    {1'b1, OP_CLZ, 32'hE16F3F10, 32'h00000014, 32'h0, 32'h0, 32'hFFFFFFFF,
     {1'b1, 4'd3, 32'd0, 32'h00000014, 32'h0, 1'b0, STOP_NONE}},
    {1'b1, OP_CLZ, 32'hE16F3F10, 32'h00000018, 32'h0, 32'h0, 32'h00000001,
     {1'b1, 4'd3, 32'd31, 32'h00000018, 32'h0, 1'b0, STOP_NONE}},
    {1'b1, OP_CLZ, 32'hE16FFF10, 32'h0000001C, 32'h0, 32'h0, 32'h00000001,
     {1'b0, 4'd0, 32'h0, 32'h0000001C, 32'h0, 1'b0, STOP_NONE}},
    // bitfield clear: full width, then msb below lsb
    {1'b1, OP_BFC, 32'hE7DF001F, 32'h00000020, 32'hFFFFFFFF, 32'h0, 32'h0,
     {1'b1, 4'd0, 32'h0, 32'h00000020, 32'h0, 1'b0, STOP_NONE}},
    {1'b1, OP_BFC, 32'hE7C3251F, 32'h00000024, 32'hFFFFFFFF, 32'h0, 32'h0,
     {1'b0, 4'd0, 32'h0, 32'h00000024, 32'h0, 1'b0, STOP_NONE}},
    // bitfield insert: full width, destination pc, top bit only; then a clear of the lowest bit
    {1'b1, OP_BFI, 32'hE7DF4010, 32'h00000028, 32'h0, 32'hA5A5A5A5, 32'h0,
     {1'b1, 4'd4, 32'hA5A5A5A5, 32'h00000028, 32'h0, 1'b0, STOP_NONE}},
    {1'b1, OP_BFI, 32'hE7DFF010, 32'h0000002C, 32'h0, 32'hFFFFFFFF, 32'h0,
     {1'b0, 4'd0, 32'h0, 32'h0000002C, 32'h0, 1'b0, STOP_NONE}},
    {1'b1, OP_BFI, 32'hE7DF5F90, 32'h00000030, 32'h0, 32'hFFFFFFFF, 32'h0,
     {1'b1, 4'd5, 32'h80000000, 32'h00000030, 32'h0, 1'b0, STOP_NONE}},
    {1'b1, OP_BFC, 32'hE7C0601F, 32'h00000034, 32'hFFFFFFFF, 32'h0, 32'h0,
     {1'b1, 4'd6, 32'hFFFFFFFE, 32'h00000034, 32'h0, 1'b0, STOP_NONE}},
    // status changes from here on, left to the predictor
    {1'b0, OP_SETEND, 32'hF1010200, 32'h00000038, 32'h0, 32'h0, 32'h0, NO_CHECK},
    {1'b0, OP_CPS, 32'hF10E01DF, 32'h0000003C, 32'h0, 32'h0, 32'h0, NO_CHECK},
    {1'b0, OP_MRS, 32'hE10F7000, 32'h00000040, 32'h0, 32'h0, 32'h0, NO_CHECK},
    {1'b0, OP_SVC, 32'hEF000000, 32'h00008004, 32'h0, 32'h0, 32'h0, NO_CHECK},
    {1'b0, OP_MRS, 32'hE14F2000, 32'h0000000C, 32'h0, 32'h0, 32'h0, NO_CHECK},
    {1'b0, OP_MRS, 32'hE14FF000, 32'h00000010, 32'h0, 32'h0, 32'h0, NO_CHECK},
    {1'b0, OP_CPS, 32'hF10801C0, 32'h00000014, 32'h0, 32'h0, 32'h0, NO_CHECK},
    {1'b0, OP_SETEND, 32'hF1010000, 32'h00000018, 32'h0, 32'h0, 32'h0, NO_CHECK},
    {1'b0, OP_MRS, 32'hE10FE000, 32'h0000001C, 32'h0, 32'h0, 32'h0, NO_CHECK}
  };

  logic clk;
  logic rst_n;

  abx_in_if  in_ch ();
  abx_out_if out_ch ();

  arm_system_bitfield_exec dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  // instructions waiting to be offered, results waiting to come back
  instr_slot_t instr_q [$];
  abx_out_t    retire_q [$];

  // shadow status words of the predictor
  logic [31:0] cpsr_m;
  logic [31:0] spsr_m;

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  pressure_go;
  bit  hold_off;
  int  mismatch_cnt;
  int  cycle_cnt;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // reset once, with every input at a known value from time zero
  initial begin
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // next state and result of one instruction; updates the shadow status words
  function automatic abx_out_t execute_instr(abx_in_t ins);
    abx_out_t    res;
    logic [3:0]  rd;
    logic [4:0]  lsb;
    logic [4:0]  msb;
    logic [5:0]  fwidth;
    logic [32:0] ones;
    logic [31:0] fmask;
    logic [31:0] aif;
    rd     = ins.instr_word[15:12];
    lsb    = ins.instr_word[11:7];
    msb    = ins.instr_word[20:16];
    // field mask from lsb to msb, only meaningful when msb >= lsb
    fwidth = {1'b0, msb} - {1'b0, lsb} + 6'd1;
    ones   = (33'd1 << fwidth) - 33'd1;
    fmask  = ones[31:0] << lsb;
    res        = '0;
    res.pc_out = ins.next_pc;
    case (ins.opcode)
      OP_SVC: begin
        // supervisor entry: save status, link, svc mode, irq masked, thumb and it cleared
        spsr_m = cpsr_m;
        cpsr_m = ((cpsr_m & ~MODE_MASK) | MODE_SVC | I_MASK) & ~T_MASK & ~IT_MASK;
        res.reg_write = 1'b1;
        res.reg_index = LR_INDEX;
        res.reg_value = ins.next_pc;
        res.pc_out    = SVC_VECTOR;
      end
      OP_MRS: begin
        if (rd != PC_INDEX) begin
          res.reg_write = 1'b1;
          res.reg_index = rd;
          res.reg_value = ins.instr_word[22] ? spsr_m : cpsr_m;
        end
      end
      OP_SETEND: begin
        cpsr_m = ins.instr_word[9] ? (cpsr_m | E_MASK) : (cpsr_m & ~E_MASK);
      end
      OP_CPS: begin
        aif = (ins.instr_word[8] ? A_MASK : '0) | (ins.instr_word[7] ? I_MASK : '0) |
              (ins.instr_word[6] ? F_MASK : '0);
        cpsr_m = ins.instr_word[18] ? (cpsr_m | aif) : (cpsr_m & ~aif);
        if (ins.instr_word[17]) begin
          cpsr_m = (cpsr_m & ~MODE_MASK) | (ins.instr_word & MODE_MASK);
        end
      end
      OP_BFC, OP_BFI: begin
        if (msb >= lsb && rd != PC_INDEX) begin
          res.reg_write = 1'b1;
          res.reg_index = rd;
          res.reg_value = ins.rd_value & ~fmask;
          if (ins.opcode == OP_BFI) begin
            res.reg_value = res.reg_value | ((ins.rn_value << lsb) & fmask);
          end
        end
      end
      OP_CLZ: begin
        if (rd != PC_INDEX) begin
          res.reg_write = 1'b1;
          res.reg_index = rd;
          res.reg_value = 32'd32;
          for (int i = 31; i >= 0; i--) begin
            if (ins.rm_value[i]) begin
              res.reg_value = 32'(31 - i);
              break;
            end
          end
        end
      end
      OP_BKPT: begin
        res.halt       = 1'b1;
        res.stop_cause = STOP_BREAK;
      end
      OP_DEADBEEF: begin
        res.halt       = 1'b1;
        res.stop_cause = STOP_MARKER;
      end
      default: ;
    endcase
    res.status_word = cpsr_m;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_cnt < REPORT_MAX) begin
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    end
    mismatch_cnt++;
  endtask

  // instruction side: hold valid and data until the transaction, then maybe idle
  always @(posedge clk) begin : drive_instr
    abx_out_t pred;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        // the predictor runs in acceptance order, so status always stays in step
        pred = execute_instr(instr_q[0].ins);
        retire_q.push_back(instr_q[0].chk ? instr_q[0].want : pred);
        void'(instr_q.pop_front());
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (instr_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= instr_q[0].ins;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result side: random stalls, plus a long hold-off while pressure is on
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // the hold-off keeps its own cycle count so the sender can fill the pipe
  initial begin
    hold_off = 1'b0;
    wait (pressure_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // each result transaction against the oldest expectation, field by field
  always @(posedge clk) begin : check_result
    abx_out_t got;
    abx_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (retire_q.size() == 0) begin
        report_mismatch("result with none outstanding, status_word", got.status_word, '0);
      end else begin
        want = retire_q.pop_front();
        if (got.reg_write !== want.reg_write)
          report_mismatch("reg_write", 32'(got.reg_write), 32'(want.reg_write));
        if (got.reg_index !== want.reg_index)
          report_mismatch("reg_index", 32'(got.reg_index), 32'(want.reg_index));
        if (got.reg_value !== want.reg_value)
          report_mismatch("reg_value", got.reg_value, want.reg_value);
        if (got.pc_out !== want.pc_out)
          report_mismatch("pc_out", got.pc_out, want.pc_out);
        if (got.status_word !== want.status_word)
          report_mismatch("status_word", got.status_word, want.status_word);
        if (got.halt !== want.halt)
          report_mismatch("halt", 32'(got.halt), 32'(want.halt));
        if (got.stop_cause !== want.stop_cause)
          report_mismatch("stop_cause", 32'(got.stop_cause), 32'(want.stop_cause));
      end
    end
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // random instructions: mostly real opcodes, a few unused codes
  task automatic queue_random(input int count);
    instr_slot_t s;
    for (int n = 0; n < count; n++) begin
      s = '0;
      if ($urandom_range(99) < 5) begin
        s.ins.opcode = 4'($urandom_range(OP_UNUSED_MAX, OP_UNUSED_MIN));
      end else begin
        s.ins.opcode = 4'($urandom_range(OP_DEADBEEF, OP_NOP));
      end
      s.ins.instr_word = $urandom;
      s.ins.next_pc    = $urandom;
      case ($urandom_range(7))
        0:       s.ins.rd_value = '0;
        1:       s.ins.rd_value = '1;
        default: s.ins.rd_value = $urandom;
      endcase
      s.ins.rn_value = ($urandom_range(7) == 0) ? '1 : $urandom;
      // spread leading-zero counts over the whole range
      s.ins.rm_value = $urandom >> $urandom_range(32);
      instr_q.push_back(s);
    end
  endtask

  task automatic wait_idle();
    while (instr_q.size() != 0 || retire_q.size() != 0) @(negedge clk);
  endtask

  // phases: directed rows, then random with different idle patterns
  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pressure_go    = 1'b0;
    mismatch_cnt   = 0;
    cycle_cnt      = 0;
    // status words of the predictor start from reset
    cpsr_m         = '0;
    spsr_m         = '0;
    @(posedge rst_n);
    @(negedge clk);

    foreach (DIR_TAB[i]) instr_q.push_back(DIR_TAB[i]);
    wait_idle();

    // back to back, no idling on either side
    queue_random(400);
    wait_idle();

    // sparse sender
    send_idle_pct = 87;
    queue_random(400);
    wait_idle();

    // slow receiver
    send_idle_pct  = 0;
    recv_stall_pct = 87;
    queue_random(400);
    wait_idle();

    // both sides idle now and then
    send_idle_pct  = 32;
    recv_stall_pct = 32;
    queue_random(400);
    wait_idle();

    // receiver holds off while the sender keeps offering, so the input backs up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pressure_go    = 1'b1;
    queue_random(400);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
